[sv/fsft_pkg.sv]
// Shared types, codes and constants of the fixed step frame timer.
`default_nettype none
package fsft_pkg;

  typedef logic [2:0] op_t;
  localparam op_t OP_ADVANCE = 3'd0;
  localparam op_t OP_PAUSE   = 3'd1;
  localparam op_t OP_RESUME  = 3'd2;
  localparam op_t OP_CONSUME = 3'd3;
  localparam op_t OP_CLEAR   = 3'd4;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ENABLE     = 3'd0;
  localparam cfg_idx_t CFG_TIME_SCALE = 3'd1;
  localparam cfg_idx_t CFG_FIXED_STEP = 3'd2;
  localparam cfg_idx_t CFG_MAX_FRAME  = 3'd3;
  localparam cfg_idx_t CFG_WINDOW     = 3'd4;

  localparam logic [14:0] SCALE_RESET     = 15'd256;
  localparam logic [14:0] SCALE_MAX       = 15'd25600;
  localparam logic [23:0] MAX_FRAME_RESET = 24'd250000;
  localparam logic [23:0] WINDOW_RESET    = 24'd1000000;
  localparam logic [27:0] RATE_NUMER      = 28'd256000000;
  localparam logic [23:0] INTERP_ONE      = 24'd65536;
  localparam int          DIV_STEPS       = 24;

  typedef struct packed {
    logic        enable;
    logic [14:0] time_scale_q8;
    logic [23:0] fixed_step_us;
    logic [23:0] max_frame_us;
    logic [23:0] stats_window_us;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num_hi;
    logic [23:0] num_lo;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [23:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic        paused;
    logic [23:0] max_frame_time;
    logic [23:0] min_frame_time;
    logic [23:0] frame_rate_q8;
    logic [23:0] interpolation_q16;
    logic        step_pending;
    logic        step_taken;
    logic [31:0] frame_count;
    logic [63:0] sim_us;
    logic [23:0] effective_dt;
    logic [23:0] delta_time;
  } result_t;

endpackage
`default_nettype wire

[sv/fsft_div.sv]
// Shared restoring divider, one quotient bit per cycle, 24-bit quotient.
`default_nettype none
module fsft_div
  import fsft_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [23:0] lo;
  logic [23:0] quo;
  logic [31:0] dvs;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    trial = {rem, lo[23]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= req.num_hi;
        lo   <= req.num_lo;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= ge ? diff[31:0] : trial[31:0];
        lo  <= {lo[22:0], 1'b0};
        quo <= {quo[22:0], ge};
        cnt <= cnt + 5'd1;
        if (cnt == 5'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule
`default_nettype wire

[sv/fsft_seq.sv]
// Sequencer, timer state, shared multiplier and divider control.
`default_nettype none
module fsft_seq
  import fsft_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        cfg_step_wr,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire op_t         in_op,
  input  wire logic [23:0] in_raw,
  input  wire logic        out_free,
  output logic             res_load,
  output result_t          res
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_OP    = 11'b00000000010,
    S_CLAMP = 11'b00000000100,
    S_ACC   = 11'b00000001000,
    S_WIN   = 11'b00000010000,
    S_IQ    = 11'b00000100000,
    S_IW    = 11'b00001000000,
    S_RQ    = 11'b00010000000,
    S_RS    = 11'b00100000000,
    S_RW    = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t      state;
  op_t         op;
  logic [23:0] raw;
  logic [59:0] prod;
  logic [23:0] dt;
  logic [63:0] sim_clock;
  logic [23:0] last_delta;
  logic [39:0] step_acc;
  logic [31:0] frames;
  logic [31:0] win_sum;
  logic [31:0] win_count;
  logic [23:0] win_min;
  logic [23:0] win_max;
  logic [63:0] win_start;
  logic        pause_flag;
  logic        taken;
  logic [23:0] interp;
  logic [23:0] rate;

  logic [14:0] scale_c;
  logic [31:0] mul_a;
  logic [27:0] mul_b;
  logic [59:0] mul_p;
  logic [63:0] sim_sum;
  logic [32:0] wsum_sum;
  logic [40:0] acc_sum;
  logic [63:0] elapsed;
  logic        step_rdy;
  logic        iq_sat;
  logic        rs_sat;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  fsft_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    scale_c = (cfg.time_scale_q8 > SCALE_MAX) ? SCALE_MAX : cfg.time_scale_q8;
    if (state == S_RQ) begin
      mul_a = win_count;
      mul_b = RATE_NUMER;
    end else begin
      mul_a = {8'b0, raw};
      mul_b = {13'b0, scale_c};
    end
    mul_p    = 60'(mul_a) * 60'(mul_b);
    sim_sum  = sim_clock + {40'b0, dt};
    wsum_sum = {1'b0, win_sum} + {9'b0, dt};
    acc_sum  = {1'b0, step_acc} + {17'b0, dt};
    elapsed  = sim_clock - win_start;
    step_rdy = (cfg.fixed_step_us != '0) && (step_acc >= {16'b0, cfg.fixed_step_us});
    iq_sat   = step_acc >= {8'b0, cfg.fixed_step_us, 8'b0};
    rs_sat   = prod[59:24] >= {4'b0, win_sum};

    div_req = '0;
    if (state == S_IQ) begin
      div_req.start   = (cfg.fixed_step_us != '0) && !iq_sat;
      div_req.num_hi  = step_acc[39:8];
      div_req.num_lo  = {step_acc[7:0], 16'b0};
      div_req.divisor = {8'b0, cfg.fixed_step_us};
    end else if (state == S_RS) begin
      div_req.start   = !rs_sat;
      div_req.num_hi  = prod[55:24];
      div_req.num_lo  = prod[23:0];
      div_req.divisor = win_sum;
    end
  end

  assign in_ready = (state == S_IDLE);
  assign res_load = (state == S_OUT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sim_clock  <= '0;
      last_delta <= '0;
      step_acc   <= '0;
      frames     <= '0;
      win_sum    <= '0;
      win_count  <= '0;
      win_min    <= '1;
      win_max    <= '0;
      win_start  <= '0;
      pause_flag <= 1'b0;
      taken      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op    <= in_op;
            raw   <= in_raw;
            taken <= 1'b0;
            state <= S_OP;
          end
        end
        S_OP: begin
          state <= S_IQ;
          unique case (op)
            OP_ADVANCE: begin
              if (cfg.enable && !pause_flag) begin
                prod  <= mul_p;
                state <= S_CLAMP;
              end else begin
                last_delta <= '0;
              end
            end
            OP_PAUSE:  pause_flag <= 1'b1;
            OP_RESUME: pause_flag <= 1'b0;
            OP_CONSUME: begin
              if (step_rdy) begin
                step_acc <= step_acc - {16'b0, cfg.fixed_step_us};
                taken    <= 1'b1;
              end
            end
            OP_CLEAR: begin
              sim_clock  <= '0;
              last_delta <= '0;
              step_acc   <= '0;
              frames     <= '0;
              win_sum    <= '0;
              win_count  <= '0;
              win_min    <= '1;
              win_max    <= '0;
              win_start  <= '0;
              pause_flag <= 1'b0;
            end
            default: ;
          endcase
        end
        S_CLAMP: begin
          dt    <= (prod[38:8] > {7'b0, cfg.max_frame_us}) ? cfg.max_frame_us : prod[31:8];
          state <= S_ACC;
        end
        S_ACC: begin
          last_delta <= dt;
          sim_clock  <= sim_sum;
          frames     <= frames + 32'd1;
          win_sum    <= wsum_sum[32] ? '1 : wsum_sum[31:0];
          if (win_count != '1) begin
            win_count <= win_count + 32'd1;
          end
          if (dt < win_min) begin
            win_min <= dt;
          end
          if (dt > win_max) begin
            win_max <= dt;
          end
          if (cfg.fixed_step_us != '0) begin
            step_acc <= acc_sum[40] ? '1 : acc_sum[39:0];
          end
          state <= S_WIN;
        end
        S_WIN: begin
          if (elapsed >= {40'b0, cfg.stats_window_us}) begin
            win_sum   <= {8'b0, dt};
            win_count <= 32'd1;
            win_min   <= dt;
            win_max   <= dt;
            win_start <= sim_clock;
          end
          state <= S_IQ;
        end
        S_IQ: begin
          if (cfg.fixed_step_us == '0) begin
            interp <= INTERP_ONE;
            state  <= S_RQ;
          end else if (iq_sat) begin
            interp <= '1;
            state  <= S_RQ;
          end else begin
            state <= S_IW;
          end
        end
        S_IW: begin
          if (div_rsp.done) begin
            interp <= div_rsp.quotient;
            state  <= S_RQ;
          end
        end
        S_RQ: begin
          if (win_count == '0 || win_sum == '0) begin
            rate  <= '0;
            state <= S_OUT;
          end else begin
            prod  <= mul_p;
            state <= S_RS;
          end
        end
        S_RS: begin
          if (rs_sat) begin
            rate  <= '1;
            state <= S_OUT;
          end else begin
            state <= S_RW;
          end
        end
        S_RW: begin
          if (div_rsp.done) begin
            rate  <= div_rsp.quotient;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg_step_wr) begin
        step_acc <= '0;
      end
    end
  end

  always_comb begin
    res.delta_time        = last_delta;
    res.effective_dt      = (cfg.fixed_step_us != '0) ? cfg.fixed_step_us : last_delta;
    res.sim_us            = sim_clock;
    res.frame_count       = frames;
    res.step_taken        = taken;
    res.step_pending      = step_rdy;
    res.interpolation_q16 = interp;
    res.frame_rate_q8     = rate;
    res.min_frame_time    = win_min;
    res.max_frame_time    = win_max;
    res.paused            = pause_flag;
  end

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !div_rsp.busy)
    else $error("divider busy while idle");

  a_empty_window: assert property (@(posedge clk) disable iff (rst)
    win_count == '0 |-> win_sum == '0 && win_max == '0)
    else $error("empty window holds data");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    win_count != '0 |-> win_min <= win_max)
    else $error("window min above max");

  a_acc_off: assert property (@(posedge clk) disable iff (rst)
    cfg.fixed_step_us == '0 |-> step_acc == '0)
    else $error("accumulator set with fixed step off");

endmodule
`default_nettype wire

[sv/fixed_step_frame_timer.sv]
// Fixed step frame timer: top level, config registers and output register.
// Each word runs the operation state, then the interpolation and frame rate
// divisions (skipped when off, empty or saturated); an enabled advance scales,
// clamps and accumulates first. One word in flight: the next input word can be
// taken from the cycle after the result is loaded.
// rst (sync) restores the register defaults and clears the sim clock, frame count, step accumulator, window and pause.
`default_nettype none
module fixed_step_frame_timer
  import fsft_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [23:0]  s_tdata,   // frame_time_us[23:0]
  input  wire logic [2:0]   s_tuser,   // operation[2:0]
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [247:0]      m_tdata,   // delta_time[23:0], effective_dt[47:24],
                                       // sim_us[111:48], frame_count[143:112],
                                       // step_taken[144], step_pending[145],
                                       // interpolation_q16[169:146],
                                       // frame_rate_q8[193:170],
                                       // min_frame_time[217:194],
                                       // max_frame_time[241:218], paused[242]
  input  wire logic         cfg_wr_en,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [23:0]  cfg_wdata
);

  cfg_t    cfg;
  logic    cfg_step_wr;
  logic    out_free;
  logic    res_load;
  result_t res;

  assign cfg_step_wr = cfg_wr_en && (cfg_index == CFG_FIXED_STEP);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable          <= 1'b0;
      cfg.time_scale_q8   <= SCALE_RESET;
      cfg.fixed_step_us   <= '0;
      cfg.max_frame_us    <= MAX_FRAME_RESET;
      cfg.stats_window_us <= WINDOW_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ENABLE:     cfg.enable          <= cfg_wdata[0];
        CFG_TIME_SCALE: cfg.time_scale_q8   <= cfg_wdata[14:0];
        CFG_FIXED_STEP: cfg.fixed_step_us   <= cfg_wdata;
        CFG_MAX_FRAME:  cfg.max_frame_us    <= cfg_wdata;
        CFG_WINDOW:     cfg.stats_window_us <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign out_free = !m_tvalid || m_tready;

  fsft_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cfg_step_wr (cfg_step_wr),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (s_tuser),
    .in_raw      (s_tdata),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tdata <= {5'b0, res};
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!m_tvalid || m_tready))
    else $error("result word overwritten before taken");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word taken while busy");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    res_load |=> m_tvalid)
    else $error("loaded result not presented");

endmodule
`default_nettype wire
